### hdl/gptok_pkg.sv
// Shared types and constants for the greedy phoneme tokenizer.
// No dependencies; imported by the tokenizer top level.
package gptok_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int MAX_MATCH   = 3;
    localparam int MAX_WORD    = 25;

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int LIM_W   = $clog2(TABLE_DEPTH + 1);
    localparam int FILL_W  = $clog2(MAX_MATCH + 1);
    localparam int SLOT_W  = (MAX_MATCH > 1) ? $clog2(MAX_MATCH) : 1;
    localparam int TEXT_W  = 8 * MAX_MATCH;
    localparam int CNT_W   = $clog2(MAX_WORD + 1);
    localparam int COUNT_W = 7;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT,
        ST_TERM
    } t_state;

    typedef struct packed {
        logic [7:0]        code;
        logic [1:0]        len;
        logic [TEXT_W-1:0] text;
    } t_entry;

    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;

endpackage

### hdl/greedy_phoneme_tokenizer.sv
// Greedy longest-match phoneme tokenizer: table memory, lookahead and scan sequencer.
// Depends on gptok_pkg (types, table geometry, state encoding).
//
// Usage: load items (tuser = load) write one table entry each.
// Word characters are folded to upper case and collect in a three-character
// lookahead; once it is full, one match pass runs. A match pass reads the table
// through its single read port, one entry per cycle, and checks every entry
// against all three prefix lengths at once. Sending a code and sending the
// terminator both hold while the output register is still full. End of word runs
// up to two passes to drain the lookahead and then sends the terminator (code 0,
// tlast high). The input side is ready only when no pass or result is in progress;
// a result sits in the output register until taken, and a new item may enter while
// it waits. The table has no reset: entries read before being written give
// undefined results.
module greedy_phoneme_tokenizer
    import gptok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] entry_index, [29:6] entry_text, [31:30] entry_len,
    // [39:32] entry_code, [47:40] char_in
    input  logic [47:0] i_s_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_tuser,
    // result side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] code
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Unpack the request fields.
    logic [ADDR_W-1:0] s_index;
    logic [TEXT_W-1:0] s_text;
    logic [1:0]        s_len;
    logic [7:0]        s_code;
    logic [7:0]        s_char;
    t_kind             s_kind;

    assign s_index = i_s_tdata[5:0];
    assign s_text  = i_s_tdata[29:6];
    assign s_len   = i_s_tdata[31:30];
    assign s_code  = i_s_tdata[39:32];
    assign s_char  = i_s_tdata[47:40];
    assign s_kind  = t_kind'(i_s_tuser);

    // Configuration register.
    logic [COUNT_W-1:0] r_entry_count;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {25'd0, r_entry_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_wr && paddr[2] == REG_ENTRY_COUNT) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    // Entries searched: clamp the register to the table depth.
    logic [LIM_W-1:0] lim;
    assign lim = (r_entry_count > COUNT_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
                                                         : LIM_W'(r_entry_count);

    // Control and datapath registers.
    t_state             r_state, n_state;
    logic [7:0]         r_chars [MAX_MATCH];
    logic [7:0]         n_chars [MAX_MATCH];
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_flush, n_flush;
    logic [LIM_W-1:0]   r_idx, n_idx;
    logic               r_rd_valid, n_rd_valid;
    logic [MAX_MATCH-1:0] r_found, n_found;
    logic [7:0]         r_hit_code [MAX_MATCH];
    logic [7:0]         n_hit_code [MAX_MATCH];
    logic [7:0]         r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_code, n_out_code;
    logic               r_out_end, n_out_end;

    // Table memory: one write port for loads, one registered read port for the scan.
    t_entry             mem [TABLE_DEPTH];
    t_entry             r_rd_data;
    logic               mem_we;
    logic               rd_en;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[s_index] <= '{code: s_code, len: s_len, text: s_text};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[ADDR_W-1:0]];
        end
    end

    // Entry length with trailing spaces stripped.
    function automatic logic [1:0] eff_len(input t_entry e);
        logic [1:0] n;
        n = e.len;
        for (int j = MAX_MATCH; j >= 1; j--) begin
            if (n == 2'(j) && e.text[8*(j-1) +: 8] == SPACE_CHAR) begin
                n = 2'(j - 1);
            end
        end
        return n;
    endfunction

    // Shared compare unit: check the entry just read at every prefix length.
    logic [1:0]           rd_len;
    logic [MAX_MATCH-1:0] hit;

    always_comb begin
        rd_len = eff_len(r_rd_data);
        for (int l = 1; l <= MAX_MATCH; l++) begin
            hit[l-1] = (rd_len == 2'(l)) && (FILL_W'(l) <= r_fill);
            for (int k = 0; k < l; k++) begin
                if (r_rd_data.text[8*k +: 8] != r_chars[k]) begin
                    hit[l-1] = 1'b0;
                end
            end
        end
    end

    // Decision: longest prefix that found an entry, else drop one character.
    logic [FILL_W-1:0] used;
    logic [7:0]        dec_code;
    logic [7:0]        shifted [MAX_MATCH];

    always_comb begin
        used     = FILL_W'(1);
        dec_code = 8'd0;
        for (int l = 1; l <= MAX_MATCH; l++) begin
            if (r_found[l-1]) begin
                used     = FILL_W'(l);
                dec_code = r_hit_code[l-1];
            end
        end
        for (int k = 0; k < MAX_MATCH; k++) begin
            shifted[k] = 8'd0;
            for (int s = 1; s <= MAX_MATCH; s++) begin
                if (used == FILL_W'(s) && k + s < MAX_MATCH
                    && FILL_W'(k + s) < r_fill) begin
                    shifted[k] = r_chars[(k + s) % MAX_MATCH];
                end
            end
        end
    end

    logic       accept;
    logic       slot_free;
    logic [7:0] folded;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign folded     = (s_char inside {[8'h61:8'h7a]}) ? s_char - CASE_DELTA : s_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_MATCH; k++) begin
                r_chars[k] <= 8'd0;
            end
            r_fill      <= '0;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_found     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_chars     <= n_chars;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_flush     <= n_flush;
            r_idx       <= n_idx;
            r_rd_valid  <= n_rd_valid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_code <= n_hit_code;
        r_pend     <= n_pend;
        r_out_code <= n_out_code;
        r_out_end  <= n_out_end;
    end

    always_comb begin
        n_state     = r_state;
        n_chars     = r_chars;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_flush     = r_flush;
        n_idx       = r_idx;
        n_rd_valid  = 1'b0;
        n_found     = r_found;
        n_hit_code  = r_hit_code;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_code  = r_out_code;
        n_out_end   = r_out_end;
        mem_we      = 1'b0;
        rd_en       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_LOAD: begin
                            mem_we = 1'b1;
                        end
                        KIND_CHAR: begin
                            // Ignore characters past the word limit.
                            if (r_cnt < CNT_W'(MAX_WORD)) begin
                                n_cnt = r_cnt + 1'b1;
                                n_chars[r_fill[SLOT_W-1:0]] = folded;
                                n_fill = r_fill + 1'b1;
                                if (r_fill == FILL_W'(MAX_MATCH - 1)) begin
                                    n_flush = 1'b0;
                                    n_idx   = '0;
                                    n_found = '0;
                                    n_state = ST_SCAN;
                                end
                            end
                        end
                        KIND_END: begin
                            n_flush = 1'b1;
                            n_idx   = '0;
                            n_found = '0;
                            n_state = (r_fill != '0) ? ST_SCAN : ST_TERM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle; the compare follows in the cycle after the read.
                if (r_idx < lim) begin
                    rd_en      = 1'b1;
                    n_rd_valid = 1'b1;
                    n_idx      = r_idx + 1'b1;
                end
                if (r_rd_valid) begin
                    for (int l = 0; l < MAX_MATCH; l++) begin
                        // Keep the lowest index per length.
                        if (hit[l] && !r_found[l]) begin
                            n_found[l]    = 1'b1;
                            n_hit_code[l] = r_rd_data.code;
                        end
                    end
                end else if (r_idx >= lim) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_chars = shifted;
                n_fill  = r_fill - used;
                n_pend  = dec_code;
                n_idx   = '0;
                n_found = '0;
                if (dec_code != 8'd0) begin
                    n_state = ST_EMIT;
                end else if (!r_flush) begin
                    n_state = ST_IDLE;
                end else if (r_fill != used) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_TERM;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_pend;
                    n_out_end   = 1'b0;
                    if (!r_flush) begin
                        n_state = ST_IDLE;
                    end else if (r_fill != '0) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_TERM;
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = 8'd0;
                    n_out_end   = 1'b1;
                    n_cnt       = '0;
                    n_flush     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_code;
    assign o_m_tlast  = r_out_end;

    // The lookahead never rests full between items.
    a_fill_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_fill < FILL_W'(MAX_MATCH))
        else $error("lookahead full while idle");

    // The character count stays within the word limit.
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_WORD))
        else $error("word character count overflow");

    // A prefix length is only marked found if the lookahead holds that many chars.
    a_found_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DECIDE |->
            !(r_found[2] && r_fill != 2'd3) && !(r_found[1] && r_fill < 2'd2))
        else $error("match longer than lookahead");

    // The terminator goes out with an empty lookahead and clears the count.
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_TERM && slot_free |=>
            o_m_tvalid && o_m_tlast && r_cnt == '0 && r_fill == '0)
        else $error("terminator not issued cleanly");

endmodule

### verif/greedy_phoneme_tokenizer_test.sv
`timescale 1ns / 100ps
// Self-checking bench for greedy_phoneme_tokenizer: streams table loads and words in bursts,
// tokenizes every accepted request with its own table and lookahead copy, checks each code.
// Depends on gptok_pkg and the tokenizer top level under hdl/.
module greedy_phoneme_tokenizer_test;
    import gptok_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 200;    // covers one full match pass plus emit, with margin
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;
    localparam logic [7:0] UPPER_A = 8'h41;

    // receiver stall patterns
    localparam int RX_OPEN = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  idx;
        logic [23:0] text;
        logic [1:0]  len;
        logic [7:0]  code;
        logic [7:0]  ch;
    } t_request;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_token;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         o_s_tready;
    // [5:0] entry_index, [29:6] entry_text, [31:30] entry_len,
    // [39:32] entry_code, [47:40] char_in
    logic [47:0] s_tdata  = '0;
    // [1:0] kind
    logic [1:0]  s_tuser  = '0;
    wire         o_m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] code
    wire  [7:0]  o_m_tdata;
    wire         o_m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    wire  [31:0] prdata;
    wire         pready;

    greedy_phoneme_tokenizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Tokenizer state as the bench sees it
    // ---------------------------------------------------------------------
    logic [23:0] tbl_text [TABLE_DEPTH];
    logic [1:0]  tbl_len  [TABLE_DEPTH];
    logic [7:0]  tbl_code [TABLE_DEPTH];
    logic [7:0]  la_chars [MAX_MATCH];
    int unsigned la_fill     = 0;
    int unsigned word_chars  = 0;
    int unsigned entry_count = 0;

    t_request request_q [$];       // requests waiting for the driver
    t_token   expected_codes [$];  // codes the block still owes us

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // Entry length with trailing spaces stripped; zero never matches.
    function automatic int unsigned trimmed_len(int unsigned i);
        int unsigned n;
        n = tbl_len[i];
        while (n > 0 && tbl_text[i][8*(n-1) +: 8] == SPACE_CHAR)
            n--;
        return n;
    endfunction

    function automatic bit prefix_hits(int unsigned i, int unsigned n);
        int unsigned k;
        if (trimmed_len(i) != n)
            return 1'b0;
        for (k = 0; k < n; k++)
            if (tbl_text[i][8*k +: 8] != la_chars[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Consume the longest matching prefix of the lookahead (or drop one char).
    function automatic void match_head();
        int unsigned lim, used, n, i, k;
        logic [7:0]  hit_code;
        bit          found;
        t_token      tok;
        lim      = (entry_count < TABLE_DEPTH) ? entry_count : TABLE_DEPTH;
        used     = 1;
        hit_code = '0;
        found    = 1'b0;
        for (n = la_fill; n > 0 && !found; n--)
            for (i = 0; i < lim && !found; i++)
                if (prefix_hits(i, n)) begin
                    found    = 1'b1;
                    used     = n;
                    hit_code = tbl_code[i];
                end
        for (k = 0; k + used < la_fill; k++)
            la_chars[k] = la_chars[k + used];
        la_fill -= used;
        for (k = la_fill; k < MAX_MATCH; k++)
            la_chars[k] = '0;
        // silent entries are consumed without a result
        if (hit_code != 0) begin
            tok.code = hit_code;
            tok.last = 1'b0;
            expected_codes.push_back(tok);
        end
    endfunction

    function automatic void tokenize_request(t_request r);
        logic [7:0] c;
        t_token     tok;
        case (r.kind)
            KIND_LOAD: begin
                tbl_text[r.idx] = r.text;
                tbl_len[r.idx]  = r.len;
                tbl_code[r.idx] = r.code;
            end
            KIND_CHAR: begin
                // chars past the word limit are ignored outright
                if (word_chars < MAX_WORD) begin
                    word_chars++;
                    c = r.ch;
                    if (c >= LOWER_A && c <= LOWER_Z)
                        c = c - CASE_DELTA;
                    if (la_fill < MAX_MATCH) begin
                        la_chars[la_fill] = c;
                        la_fill++;
                    end
                    if (la_fill >= MAX_MATCH)
                        match_head();
                end
            end
            KIND_END: begin
                while (la_fill > 0)
                    match_head();
                tok.code = '0;
                tok.last = 1'b1;
                expected_codes.push_back(tok);
                word_chars = 0;
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Request builders
    // ---------------------------------------------------------------------
    // Fields a kind does not use still carry random bits.
    function automatic t_request blank_request(t_kind k);
        t_request r;
        r.kind = k;
        r.idx  = 6'($urandom_range(0, 63));
        r.text = 24'($urandom_range(0, 24'hFFFFFF));
        r.len  = 2'($urandom_range(0, 3));
        r.code = 8'($urandom_range(0, 255));
        r.ch   = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic logic [23:0] text_of(string s);
        logic [23:0] t;
        int          i;
        t = '0;
        for (i = 0; i < s.len() && i < 3; i++)
            t[8*i +: 8] = s[i];
        return t;
    endfunction

    task automatic queue_load(int unsigned idx, logic [23:0] text, logic [1:0] len,
                              logic [7:0] code);
        t_request r;
        r      = blank_request(KIND_LOAD);
        r.idx  = 6'(idx);
        r.text = text;
        r.len  = len;
        r.code = code;
        request_q.push_back(r);
    endtask

    task automatic queue_char(logic [7:0] c);
        t_request r;
        r    = blank_request(KIND_CHAR);
        r.ch = c;
        request_q.push_back(r);
    endtask

    task automatic queue_word(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_char(s[i]);
        request_q.push_back(blank_request(KIND_END));
    endtask

    // Mostly letters A..H so entries actually hit; sometimes junk text or length zero.
    task automatic queue_random_load(int unsigned idx);
        logic [23:0] text;
        int unsigned b, pick;
        for (b = 0; b < 3; b++) begin
            pick = $urandom_range(0, 8);
            text[8*b +: 8] = (pick == 8) ? SPACE_CHAR : UPPER_A + 8'(pick);
        end
        if ($urandom_range(0, 7) == 0)
            text = 24'($urandom_range(0, 24'hFFFFFF));
        queue_load(idx, text,
                   ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                   ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
    endtask

    function automatic logic [7:0] random_char();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            return UPPER_A + 8'(pick);
        if (pick < 16)
            return LOWER_A + 8'(pick - 8);
        if (pick == 16)
            return SPACE_CHAR;
        return 8'($urandom_range(0, 255));
    endfunction

    // A word with random content; now and then a load or an unused kind cuts into it.
    task automatic queue_random_word();
        int unsigned n, i;
        n = ($urandom_range(0, 11) == 0) ? $urandom_range(24, 30) : $urandom_range(0, 8);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 23))
                0:       queue_random_load($urandom_range(0, 63));
                1:       request_q.push_back(blank_request(KIND_NONE));
                default: ;
            endcase
            queue_char(random_char());
        end
        request_q.push_back(blank_request(KIND_END));
    endtask

    task automatic queue_random_phase(int unsigned n_items);
        int unsigned start;
        start = request_q.size();
        while (request_q.size() - start < n_items) begin
            if ($urandom_range(0, 9) == 0)
                queue_random_load($urandom_range(0, 63));
            else
                queue_random_word();
        end
    endtask

    // Hold until every request is in and every code is out, then let the block settle.
    task automatic wait_idle();
        @(negedge i_clk);
        while (request_q.size() != 0 || s_tvalid || expected_codes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_entry_count(int unsigned value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_ENTRY_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        entry_count = value & 7'h7F;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------------
    t_request    cur_req = '0;
    t_request    nxt_req;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready)
                tokenize_request(cur_req);
            // advance only when nothing is held or the held request just went in
            if (!s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    nxt_req  = request_q.pop_front();
                    cur_req  <= nxt_req;
                    s_tdata  <= {nxt_req.ch, nxt_req.code, nxt_req.len, nxt_req.text,
                                 nxt_req.idx};
                    s_tuser  <= nxt_req.kind;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor with its own stall pattern
    // ---------------------------------------------------------------------
    int unsigned stall_tick = 0;
    int unsigned stall_mode = RX_OPEN;
    t_token      want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_codes.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result: code %02h last %0b", o_m_tdata, o_m_tlast);
                end else begin
                    want = expected_codes.pop_front();
                    if (o_m_tdata !== want.code || o_m_tlast !== want.last) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("result mismatch: code %02h (want %02h) last %0b (want %0b)",
                                     o_m_tdata, want.code, o_m_tlast, want.last);
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 50 == 0)
                stall_mode = $urandom_range(RX_OPEN, RX_SLOW);
            case (stall_mode)
                RX_OPEN: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (stall_tick % 4 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("greedy_phoneme_tokenizer_test: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        int unsigned sweep [8];
        int          i;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            tbl_text[i] = '0;
            tbl_len[i]  = '0;
            tbl_code[i] = '0;
        end
        for (i = 0; i < MAX_MATCH; i++)
            la_chars[i] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Table with a three-char entry, a two-char silent entry, a duplicate "A"
        // (lower slot must win), a trailing-space entry, a zero-length entry and
        // an all-space entry; top slot gets all-ones text and code.
        queue_load(0, text_of("SCH"), 2'd3, 8'h51);
        queue_load(1, text_of("CH"), 2'd2, 8'h52);
        queue_load(2, text_of("A"), 2'd1, 8'h01);
        queue_load(3, text_of("E "), 2'd2, 8'h03);
        queue_load(4, text_of("SH"), 2'd2, 8'h00);
        queue_load(5, text_of("A"), 2'd1, 8'h77);
        queue_load(6, text_of("B"), 2'd0, 8'h44);
        queue_load(7, text_of("ZZZ"), 2'd3, 8'hFF);
        queue_load(8, text_of("   "), 2'd3, 8'h20);
        queue_load(63, 24'hFFFFFF, 2'd3, 8'hFF);
        // entry count still zero after reset: chars drop, only the terminator comes
        queue_word("a");
        request_q.push_back(blank_request(KIND_NONE));
        wait_idle();

        write_entry_count(9);
        queue_word("schade");
        queue_word("she");
        queue_char(8'h00);
        queue_char(8'hFF);
        request_q.push_back(blank_request(KIND_END));
        queue_word("");
        wait_idle();

        // Fill every slot so that any entry count may be searched from here on.
        for (i = 0; i < TABLE_DEPTH; i++)
            queue_random_load(i);
        wait_idle();

        sweep = '{64, 1, 127, 33, 0, 100, 2, 0};
        sweep[7] = $urandom_range(3, 64);
        for (i = 0; i < 8; i++) begin
            write_entry_count(sweep[i]);
            queue_random_phase(6);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("greedy_phoneme_tokenizer_test: done, clean");
        end else begin
            $display("greedy_phoneme_tokenizer_test: done, errors");
        end
        $finish;
    end

endmodule
